>>> sv/rrig_pkg.sv
// rrig_pkg: shared constants and codes for the row request item grouper.
// No dependencies; imported by row_request_item_grouper.
package rrig_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int ROW_BITS  = 48;
    localparam int ITEM_BITS = $clog2(MAX_ITEMS);
    localparam int CNT_BITS  = $clog2(MAX_ITEMS + 1);
    localparam int CFG_BITS  = 7;
    localparam int RUN_BITS  = 16;
    localparam int KIND_BITS = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_MEMBER = 2'd0,
        KIND_CLOSE  = 2'd1,
        KIND_ERROR  = 2'd2
    } t_record_kind;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_ROW  = 1'b1
    } t_command;

endpackage

>>> sv/rrig_ram.sv
// rrig_ram: generic single-write, single-read RAM with registered read data.
// Standalone; used for the boundary table of row_request_item_grouper.
module rrig_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/row_request_item_grouper.sv
// row_request_item_grouper: maps row requests to items and groups them into runs.
// Depends on rrig_pkg and rrig_ram.
//
// A load transaction writes one boundary table entry. A row request scans the
// boundary table one entry per cycle through the single read port of the table
// RAM. The offset and the run-order check follow in S_CALC and S_ORDER, both on
// one shared 48-bit subtractor, and then one to three records are loaded into
// the output register as the output side takes them. The block takes no new
// transaction until the last record of the current one is loaded into the output
// register. item_count must be written by the user only while the block is idle;
// the block itself does not enforce it.
module row_request_item_grouper
    import rrig_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_BITS-1:0]  i_cfg_wr_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_command,
    input  logic [5:0]           i_table_index,
    input  logic [ROW_BITS-1:0]  i_boundary_value,
    input  logic [ROW_BITS-1:0]  i_row,
    input  logic                 i_last_row,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [KIND_BITS-1:0] o_record_kind,
    output logic [ITEM_BITS-1:0] o_item_id,
    output logic [ROW_BITS-1:0]  o_item_base_row,
    output logic [ROW_BITS-1:0]  o_member_offset,
    output logic [ROW_BITS-1:0]  o_interval_start,
    output logic [ROW_BITS-1:0]  o_interval_end,
    output logic [RUN_BITS-1:0]  o_run_rows,
    output logic                 o_last_record
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CALC,
        S_ORDER,
        S_ERR,
        S_CLOSE_PRE,
        S_MEMBER,
        S_CLOSE_LAST
    } t_state;

    t_state               r_state;
    logic [CFG_BITS-1:0]  r_item_count;

    // request
    logic [ROW_BITS-1:0]  r_row;
    logic                 r_last;

    // search
    logic [CNT_BITS-1:0]  r_rd_idx;
    logic                 r_cmp_vld;
    logic [ITEM_BITS-1:0] r_cmp_idx;
    logic [ROW_BITS-1:0]  r_prev_ent;
    logic [ITEM_BITS-1:0] r_item;
    logic [ROW_BITS-1:0]  r_base;
    logic [ROW_BITS-1:0]  r_offset;

    // run state
    logic                 r_run_open;
    logic [ITEM_BITS-1:0] r_run_item;
    logic [ROW_BITS-1:0]  r_run_base;
    logic [ROW_BITS-1:0]  r_run_start;
    logic [ROW_BITS-1:0]  r_run_end;
    logic [ROW_BITS-1:0]  r_seen_row;
    logic [RUN_BITS-1:0]  r_run_count;

    // output register
    logic                 r_out_vld;
    t_record_kind         r_out_kind;
    logic [ITEM_BITS-1:0] r_out_item;
    logic [ROW_BITS-1:0]  r_out_base;
    logic [ROW_BITS-1:0]  r_out_offset;
    logic [ROW_BITS-1:0]  r_out_start;
    logic [ROW_BITS-1:0]  r_out_end;
    logic [RUN_BITS-1:0]  r_out_rows;
    logic                 r_out_last;

    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    logic [CNT_BITS-1:0]  limit;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [ROW_BITS-1:0]  ram_rd_data;
    logic [ROW_BITS-1:0]  sub_a;
    logic [ROW_BITS-1:0]  sub_b;
    logic [ROW_BITS:0]    sub_res;
    logic                 sub_borrow;
    logic                 close_needed;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_vld || !i_stall;
    assign o_stall   = (r_state != S_IDLE);

    // a record is loaded into the output register this cycle
    assign out_load = out_free && ((r_state == S_ERR) || (r_state == S_CLOSE_PRE) ||
                                   (r_state == S_MEMBER) || (r_state == S_CLOSE_LAST));

    // counts above the table depth search the whole table
    assign limit = (r_item_count > CFG_BITS'(MAX_ITEMS)) ? CNT_BITS'(MAX_ITEMS)
                                                         : CNT_BITS'(r_item_count);

    assign ram_wr_en = in_accept && (i_command == CMD_LOAD);
    assign ram_rd_en = (r_state == S_SEARCH) && (r_rd_idx < limit);

    rrig_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_ITEMS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (i_table_index[ITEM_BITS-1:0]),
        .i_wr_data (i_boundary_value),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_idx[ITEM_BITS-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // shared subtractor: row < entry, row - base, previous_row < row
    always_comb begin
        unique case (r_state)
            S_SEARCH: begin
                sub_a = r_row;
                sub_b = ram_rd_data;
            end
            S_ORDER: begin
                sub_a = r_seen_row;
                sub_b = r_row;
            end
            default: begin
                sub_a = r_row;
                sub_b = r_base;
            end
        endcase
    end

    assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_res[ROW_BITS];

    // in S_ORDER a borrow means previous_row < row
    assign close_needed = r_run_open && ((r_item != r_run_item) || !sub_borrow);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_item_count <= CFG_BITS'(1);
            r_run_open   <= 1'b0;
            r_run_item   <= '0;
            r_run_base   <= '0;
            r_run_start  <= '0;
            r_run_end    <= '0;
            r_seen_row   <= '0;
            r_run_count  <= '0;
            r_out_vld    <= 1'b0;
            r_cmp_vld    <= 1'b0;
            r_rd_idx     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_item_count <= i_cfg_wr_data;
            end
            if (r_out_vld && !i_stall && !out_load) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    // close records report the current base of the run's item
                    if (ram_wr_en && (r_run_item != '0) &&
                        (i_table_index == r_run_item - ITEM_BITS'(1))) begin
                        r_run_base <= i_boundary_value;
                    end
                    if (in_accept && (i_command == CMD_ROW)) begin
                        r_row      <= i_row;
                        r_last     <= i_last_row;
                        r_rd_idx   <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_prev_ent <= '0;
                        r_state    <= S_SEARCH;
                    end
                end

                S_SEARCH: begin
                    r_cmp_vld <= ram_rd_en;
                    r_cmp_idx <= r_rd_idx[ITEM_BITS-1:0];
                    if (ram_rd_en) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_cmp_vld && sub_borrow) begin
                        r_item  <= r_cmp_idx;
                        r_base  <= r_prev_ent;
                        r_state <= S_CALC;
                    end else begin
                        if (r_cmp_vld) begin
                            r_prev_ent <= ram_rd_data;
                        end
                        if (!r_cmp_vld && (r_rd_idx >= limit)) begin
                            r_state <= S_ERR;
                        end
                    end
                end

                S_CALC: begin
                    r_offset <= sub_res[ROW_BITS-1:0];
                    r_state  <= S_ORDER;
                end

                S_ORDER: begin
                    r_state <= close_needed ? S_CLOSE_PRE : S_MEMBER;
                end

                S_ERR: begin
                    if (out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_kind   <= KIND_ERROR;
                        r_out_item   <= '0;
                        r_out_base   <= '0;
                        r_out_offset <= '0;
                        r_out_start  <= '0;
                        r_out_end    <= '0;
                        r_out_rows   <= '0;
                        r_out_last   <= !(r_last && r_run_open);
                        r_state      <= (r_last && r_run_open) ? S_CLOSE_LAST : S_IDLE;
                    end
                end

                S_CLOSE_PRE: begin
                    if (out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_kind   <= KIND_CLOSE;
                        r_out_item   <= r_run_item;
                        r_out_base   <= r_run_base;
                        r_out_offset <= '0;
                        r_out_start  <= r_run_start;
                        r_out_end    <= r_run_end;
                        r_out_rows   <= r_run_count;
                        r_out_last   <= 1'b0;
                        r_run_open   <= 1'b0;
                        r_state      <= S_MEMBER;
                    end
                end

                S_MEMBER: begin
                    if (out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_kind   <= KIND_MEMBER;
                        r_out_item   <= r_item;
                        r_out_base   <= r_base;
                        r_out_offset <= r_offset;
                        r_out_start  <= '0;
                        r_out_end    <= '0;
                        r_out_rows   <= '0;
                        r_out_last   <= !r_last;
                        r_run_open   <= 1'b1;
                        r_run_end    <= r_offset + 1'b1;
                        r_seen_row   <= r_row;
                        if (!r_run_open) begin
                            r_run_item  <= r_item;
                            r_run_base  <= r_base;
                            r_run_start <= r_offset;
                            r_run_count <= RUN_BITS'(1);
                        end else if (r_run_count != '1) begin
                            r_run_count <= r_run_count + 1'b1;
                        end
                        r_state <= r_last ? S_CLOSE_LAST : S_IDLE;
                    end
                end

                S_CLOSE_LAST: begin
                    if (out_free) begin
                        r_out_vld    <= 1'b1;
                        r_out_kind   <= KIND_CLOSE;
                        r_out_item   <= r_run_item;
                        r_out_base   <= r_run_base;
                        r_out_offset <= '0;
                        r_out_start  <= r_run_start;
                        r_out_end    <= r_run_end;
                        r_out_rows   <= r_run_count;
                        r_out_last   <= 1'b1;
                        r_run_open   <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_out_vld;
    assign o_record_kind    = r_out_kind;
    assign o_item_id        = r_out_item;
    assign o_item_base_row  = r_out_base;
    assign o_member_offset  = r_out_offset;
    assign o_interval_start = r_out_start;
    assign o_interval_end   = r_out_end;
    assign o_run_rows       = r_out_rows;
    assign o_last_record    = r_out_last;

endmodule
